// ===== rtl/core/tba_pkg.sv =====
// Shared types and constants of the tangent basis accumulator.
`default_nettype none
package tba_pkg;

  typedef logic signed [63:0] wide_t;
  typedef logic signed [15:0] q14_t;
  typedef logic signed [31:0] q16_t;

  localparam logic OP_CORNER = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic KIND_TRI  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int ENTRY_W = 63;
  localparam int COMP_W  = 21;

  typedef struct packed {
    logic done;
    q14_t o0;
    q14_t o1;
    q14_t o2;
  } norm_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/tba_in_if.sv =====
// Input channel: corner or read request word.
`default_nettype none
interface tba_in_if;
  import tba_pkg::*;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [9:0] vertex_index;
  q16_t       pos_x;
  q16_t       pos_y;
  q16_t       pos_z;
  q16_t       tex_u;
  q16_t       tex_v;

  modport source (output valid, operation, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                  input ready);
  modport sink (input valid, operation, vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tba_out_if.sv =====
// Result channel: tangent basis or vertex read word.
`default_nettype none
interface tba_out_if;
  import tba_pkg::*;
  logic valid;
  logic ready;
  logic result_kind;
  q14_t tan_x;
  q14_t tan_y;
  q14_t tan_z;
  q14_t bitan_x;
  q14_t bitan_y;
  q14_t bitan_z;
  logic degenerate;

  modport source (output valid, result_kind, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                  degenerate, input ready);
  modport sink (input valid, result_kind, tan_x, tan_y, tan_z, bitan_x, bitan_y, bitan_z,
                degenerate, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tba_norm.sv =====
// Iterative 3-vector normalizer: shift, square-sum, root, divide.
`default_nettype none
module tba_norm (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire tba_pkg::wide_t  c0,
  input  wire tba_pkg::wide_t  c1,
  input  wire tba_pkg::wide_t  c2,
  output tba_pkg::norm_rsp_t   rsp
);
  import tba_pkg::*;

  typedef enum logic [6:0] {
    N_IDLE  = 7'b0000001,
    N_SHIFT = 7'b0000010,
    N_SQ    = 7'b0000100,
    N_SQRT  = 7'b0001000,
    N_DLOAD = 7'b0010000,
    N_DIV   = 7'b0100000,
    N_DONE  = 7'b1000000
  } nstate_t;

  nstate_t     st_r;
  logic [63:0] a_r [3];
  logic [2:0]  neg_r;
  logic [63:0] prod_r;
  logic [63:0] sum_r;
  logic [63:0] x_r;
  logic [63:0] root_r;
  logic [4:0]  j_r;
  logic [1:0]  sk_r;
  logic [1:0]  k_r;
  logic [3:0]  i_r;
  logic [47:0] rem_r;
  logic [15:0] quo_r;
  q14_t        o_r [3];
  logic        done_r;

  logic [63:0] m;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic [47:0] dsh;
  logic [47:0] num;
  logic [31:0] sqa;
  logic [15:0] qn;

  function automatic logic [63:0] mag64(input wide_t v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  always_comb begin
    m = a_r[0];
    if (a_r[1] > m) m = a_r[1];
    if (a_r[2] > m) m = a_r[2];
    bitv  = 64'(1) << {j_r, 1'b0};
    trial = root_r + bitv;
    dsh   = {16'b0, root_r[31:0]} << i_r;
    num   = {4'b0, a_r[k_r][29:0], 14'b0} + {17'b0, root_r[31:1]};
    sqa   = a_r[sk_r][31:0];
    qn    = {quo_r[14:0], (rem_r >= dsh)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= N_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == N_DONE);
      case (st_r)
        N_IDLE: begin
          if (start) begin
            a_r[0] <= mag64(c0);
            a_r[1] <= mag64(c1);
            a_r[2] <= mag64(c2);
            neg_r  <= {c2[63], c1[63], c0[63]};
            st_r   <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (m == 64'b0) begin
            for (int k = 0; k < 3; k++) o_r[k] <= '0;
            st_r <= N_DONE;
          end else if (m[63:38] != '0) begin
            for (int k = 0; k < 3; k++) a_r[k] <= a_r[k] >> 8;
          end else if (m[63:30] != '0) begin
            for (int k = 0; k < 3; k++) a_r[k] <= a_r[k] >> 1;
          end else if (m[63:21] == '0) begin
            for (int k = 0; k < 3; k++) a_r[k] <= a_r[k] << 8;
          end else if (m[63:29] == '0) begin
            for (int k = 0; k < 3; k++) a_r[k] <= a_r[k] << 1;
          end else begin
            sk_r  <= 2'd0;
            sum_r <= '0;
            st_r  <= N_SQ;
          end
        end
        N_SQ: begin
          // square one component per cycle, add the previous square
          if (sk_r != 2'd3) prod_r <= sqa * sqa;
          if (sk_r != 2'd0) sum_r <= sum_r + prod_r;
          if (sk_r == 2'd3) begin
            x_r    <= sum_r + prod_r;
            root_r <= '0;
            j_r    <= 5'd31;
            st_r   <= N_SQRT;
          end else begin
            sk_r <= sk_r + 2'd1;
          end
        end
        N_SQRT: begin
          if (x_r >= trial) begin
            x_r    <= x_r - trial;
            root_r <= (root_r >> 1) + bitv;
          end else begin
            root_r <= root_r >> 1;
          end
          if (j_r == 5'd0) begin
            k_r  <= 2'd0;
            st_r <= N_DLOAD;
          end else begin
            j_r <= j_r - 5'd1;
          end
        end
        N_DLOAD: begin
          rem_r <= num;
          quo_r <= '0;
          i_r   <= 4'd15;
          st_r  <= N_DIV;
        end
        N_DIV: begin
          if (rem_r >= dsh) rem_r <= rem_r - dsh;
          quo_r <= qn;
          if (i_r == 4'd0) begin
            o_r[k_r] <= neg_r[k_r] ? q14_t'(-qn) : q14_t'(qn);
            if (k_r == 2'd2) begin
              st_r <= N_DONE;
            end else begin
              k_r  <= k_r + 2'd1;
              st_r <= N_DLOAD;
            end
          end else begin
            i_r <= i_r - 4'd1;
          end
        end
        N_DONE: begin
          st_r <= N_IDLE;
        end
        default: st_r <= N_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.o0   = o_r[0];
  assign rsp.o1   = o_r[1];
  assign rsp.o2   = o_r[2];
endmodule
`default_nettype wire

// ===== rtl/core/tba_sum_mem.sv =====
// Per-vertex sum table memory, one write and one registered read port.
`default_nettype none
module tba_sum_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 126
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/tangent_basis_accumulator.sv =====
// Top level of the tangent basis accumulator.
// Usage:
//   in_ch carries words of two kinds: a triangle corner or a vertex read.
//   Corners buffer until the third closes the triangle; the block then
//   emits its unit tangent, bitangent and degenerate flag on out_ch and
//   adds both vectors into per-vertex saturating sum tables.
//   A read word returns the normalized sums of one vertex on out_ch.
//   cfg_we/cfg_wdata write the degenerate threshold (reset 7).
// Flow:
//   First and second corners are only buffered. The closing corner runs
//   the shared 32x32 multiplier, two normalizer passes (shift search,
//   squares, 32 root steps, 3 x 17 divide steps), a sign step, a table
//   update per in-range vertex and the output load. A zero vector ends
//   its pass after the shift search. A read runs both normalizer passes.
//   in_ch.ready is low meanwhile.
// Reset: a clearing pass zeroes VERTEX_COUNT table entries, one a cycle;
//   in_ch.ready stays low until it ends.
// Stall: a result holds in the output register until taken; corners are
//   still accepted meanwhile, and the next result waits its turn.
`default_nettype none
module tangent_basis_accumulator #(
  parameter int VERTEX_COUNT = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tba_in_if.sink     in_ch,
  tba_out_if.source  out_ch,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);
  import tba_pkg::*;

  localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
  localparam int DW = 2 * ENTRY_W;
  localparam logic [16:0] VC_L = 17'(VERTEX_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_COUNT - 1);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_MUL   = 11'b00000000100,
    S_GET   = 11'b00000001000,
    S_NTS   = 11'b00000010000,
    S_NT    = 11'b00000100000,
    S_NBS   = 11'b00001000000,
    S_NB    = 11'b00010000000,
    S_FIX   = 11'b00100000000,
    S_RD    = 11'b01000000000,
    S_RDW   = 11'b10000000000
  } state_t;

  state_t      st_r;
  logic        out_pend_r;
  logic [15:0] thr_r;
  logic [1:0]  cnt_r;
  q16_t        c0_r [5];
  q16_t        c1_r [5];
  logic [9:0]  ids_r [3];
  q16_t        p_r [3];
  q16_t        q_r [3];
  q16_t        s1_r, t1_r, s2_r, t2_r;
  logic [3:0]  mstep_r;
  logic [3:0]  pstep_r;
  logic        pv_r;
  wide_t       prod_r;
  wide_t       acc_r;
  wide_t       vec_r [7];
  q14_t        tn_r [3];
  q14_t        bn_r [3];
  logic        degen_r;
  logic        kind_r;
  logic        rng_r;
  logic [1:0]  k_r;
  logic [AW-1:0] clr_r;

  logic        out_valid_r;
  logic        out_kind_r;
  q14_t        out_t_r [3];
  q14_t        out_b_r [3];
  logic        out_degen_r;

  q16_t        opa, opb;
  norm_rsp_t   nrsp;
  logic        nstart;
  wide_t       nc0, nc1, nc2;
  logic        in_acc;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic [DW-1:0] rd_data;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  q16_t        cin [5];
  logic [63:0] det_mag;
  logic        degen_c;
  logic        out_free;

  function automatic q16_t delta(input q16_t a, input q16_t b);
    logic signed [32:0] d;
    d = 33'(b) - 33'(a);
    if (d > 33'sd2147483647) delta = 32'sh7fffffff;
    else if (d < -33'sd2147483647) delta = 32'sh80000001;
    else delta = d[31:0];
  endfunction

  function automatic logic in_range(input logic [9:0] idx);
    in_range = {7'b0, idx} < VC_L;
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [9:0] idx);
    logic [16:0] e;
    e = {7'b0, idx};
    to_addr = e[AW-1:0];
  endfunction

  function automatic logic [ENTRY_W-1:0] add_sat(input logic [ENTRY_W-1:0] e,
                                                 input q14_t v0, input q14_t v1,
                                                 input q14_t v2);
    logic signed [21:0] s;
    logic signed [15:0] v;
    logic [ENTRY_W-1:0] r;
    r = '0;
    for (int k = 0; k < 3; k++) begin
      v = (k == 0) ? v0 : ((k == 1) ? v1 : v2);
      s = 22'($signed(e[k*COMP_W +: COMP_W])) + 22'(v);
      if (s > 22'sd1048575) s = 22'sd1048575;
      if (s < -22'sd1048576) s = -22'sd1048576;
      r[k*COMP_W +: COMP_W] = s[20:0];
    end
    add_sat = r;
  endfunction

  function automatic wide_t sx21(input logic [COMP_W-1:0] c);
    sx21 = 64'($signed(c));
  endfunction

  assign cin[0] = in_ch.pos_x;
  assign cin[1] = in_ch.pos_y;
  assign cin[2] = in_ch.pos_z;
  assign cin[3] = in_ch.tex_u;
  assign cin[4] = in_ch.tex_v;

  assign in_ch.ready = (st_r == S_IDLE) && !out_pend_r;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // operand select for the shared multiplier
  always_comb begin
    case (mstep_r)
      4'd0:    begin opa = t2_r; opb = p_r[0]; end
      4'd1:    begin opa = t1_r; opb = q_r[0]; end
      4'd2:    begin opa = t2_r; opb = p_r[1]; end
      4'd3:    begin opa = t1_r; opb = q_r[1]; end
      4'd4:    begin opa = t2_r; opb = p_r[2]; end
      4'd5:    begin opa = t1_r; opb = q_r[2]; end
      4'd6:    begin opa = s1_r; opb = q_r[0]; end
      4'd7:    begin opa = s2_r; opb = p_r[0]; end
      4'd8:    begin opa = s1_r; opb = q_r[1]; end
      4'd9:    begin opa = s2_r; opb = p_r[1]; end
      4'd10:   begin opa = s1_r; opb = q_r[2]; end
      4'd11:   begin opa = s2_r; opb = p_r[2]; end
      4'd12:   begin opa = s1_r; opb = t2_r; end
      default: begin opa = s2_r; opb = t1_r; end
    endcase
  end

  always_comb begin
    nstart = (st_r == S_NTS) || (st_r == S_NBS);
    if (st_r == S_NBS) begin
      nc0 = vec_r[3]; nc1 = vec_r[4]; nc2 = vec_r[5];
    end else begin
      nc0 = vec_r[0]; nc1 = vec_r[1]; nc2 = vec_r[2];
    end
    det_mag = vec_r[6][63] ? 64'(-vec_r[6]) : 64'(vec_r[6]);
    degen_c = det_mag <= {32'b0, thr_r, 16'b0};
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = to_addr(ids_r[k_r]);
    wr_en   = 1'b0;
    wr_addr = to_addr(ids_r[k_r]);
    wr_data = {add_sat(rd_data[DW-1:ENTRY_W], bn_r[0], bn_r[1], bn_r[2]),
               add_sat(rd_data[ENTRY_W-1:0], tn_r[0], tn_r[1], tn_r[2])};
    case (st_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_en   = in_acc && (in_ch.operation == OP_READ);
        rd_addr = to_addr(in_ch.vertex_index);
      end
      S_RD:  rd_en = in_range(ids_r[k_r]);
      S_RDW: wr_en = 1'b1;
      default: ;
    endcase
  end

  tba_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nstart),
    .c0    (nc0),
    .c1    (nc1),
    .c2    (nc2),
    .rsp   (nrsp)
  );

  tba_sum_mem #(
    .DEPTH (VERTEX_COUNT),
    .AW    (AW),
    .DW    (DW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_r       <= '0;
      thr_r       <= 16'd7;
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
      out_pend_r  <= 1'b0;
      pv_r        <= 1'b0;
      mstep_r     <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;

      // emit a finished result once the output register is free
      if (out_pend_r && out_free) begin
        out_valid_r <= 1'b1;
        out_kind_r  <= kind_r;
        out_degen_r <= degen_r;
        for (int k = 0; k < 3; k++) begin
          out_t_r[k] <= tn_r[k];
          out_b_r[k] <= bn_r[k];
        end
        out_pend_r <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (st_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == LAST_ADDR) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            if (in_ch.operation == OP_READ) begin
              rng_r  <= in_range(in_ch.vertex_index);
              kind_r <= KIND_READ;
              st_r   <= S_GET;
            end else if (cnt_r == 2'd0) begin
              for (int k = 0; k < 5; k++) c0_r[k] <= cin[k];
              ids_r[0] <= in_ch.vertex_index;
              cnt_r    <= 2'd1;
            end else if (cnt_r == 2'd1) begin
              for (int k = 0; k < 5; k++) c1_r[k] <= cin[k];
              ids_r[1] <= in_ch.vertex_index;
              cnt_r    <= 2'd2;
            end else begin
              for (int k = 0; k < 3; k++) begin
                p_r[k] <= delta(c0_r[k], c1_r[k]);
                q_r[k] <= delta(c0_r[k], cin[k]);
              end
              s1_r     <= delta(c0_r[3], c1_r[3]);
              t1_r     <= delta(c0_r[4], c1_r[4]);
              s2_r     <= delta(c0_r[3], cin[3]);
              t2_r     <= delta(c0_r[4], cin[4]);
              ids_r[2] <= in_ch.vertex_index;
              cnt_r    <= 2'd0;
              kind_r   <= KIND_TRI;
              mstep_r  <= '0;
              pv_r     <= 1'b0;
              st_r     <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mstep_r != 4'd14) begin
            prod_r  <= opa * opb;
            pstep_r <= mstep_r;
            mstep_r <= mstep_r + 4'd1;
          end
          pv_r <= (mstep_r != 4'd14);
          if (pv_r) begin
            if (!pstep_r[0]) acc_r <= prod_r;
            else vec_r[pstep_r[3:1]] <= acc_r - prod_r;
            if (pstep_r == 4'd13) st_r <= S_NTS;
          end
        end
        S_GET: begin
          for (int k = 0; k < 3; k++) begin
            vec_r[k]     <= rng_r ? sx21(rd_data[k*COMP_W +: COMP_W]) : '0;
            vec_r[3 + k] <= rng_r ? sx21(rd_data[ENTRY_W + k*COMP_W +: COMP_W]) : '0;
          end
          degen_r <= 1'b0;
          st_r    <= S_NTS;
        end
        S_NTS: st_r <= S_NT;
        S_NT: begin
          if (nrsp.done) begin
            tn_r[0] <= nrsp.o0;
            tn_r[1] <= nrsp.o1;
            tn_r[2] <= nrsp.o2;
            st_r    <= S_NBS;
          end
        end
        S_NBS: st_r <= S_NB;
        S_NB: begin
          if (nrsp.done) begin
            bn_r[0] <= nrsp.o0;
            bn_r[1] <= nrsp.o1;
            bn_r[2] <= nrsp.o2;
            if (kind_r == KIND_TRI) begin
              st_r <= S_FIX;
            end else begin
              out_pend_r <= 1'b1;
              st_r       <= S_IDLE;
            end
          end
        end
        S_FIX: begin
          degen_r <= degen_c;
          // flip both vectors on a negative determinant of a non-degenerate triangle
          if (!degen_c && vec_r[6][63]) begin
            for (int k = 0; k < 3; k++) begin
              tn_r[k] <= -tn_r[k];
              bn_r[k] <= -bn_r[k];
            end
          end
          k_r  <= 2'd0;
          st_r <= S_RD;
        end
        S_RD: begin
          if (in_range(ids_r[k_r])) begin
            st_r <= S_RDW;
          end else if (k_r == 2'd2) begin
            out_pend_r <= 1'b1;
            st_r       <= S_IDLE;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        S_RDW: begin
          if (k_r == 2'd2) begin
            out_pend_r <= 1'b1;
            st_r       <= S_IDLE;
          end else begin
            k_r  <= k_r + 2'd1;
            st_r <= S_RD;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_kind = out_kind_r;
  assign out_ch.tan_x       = out_t_r[0];
  assign out_ch.tan_y       = out_t_r[1];
  assign out_ch.tan_z       = out_t_r[2];
  assign out_ch.bitan_x     = out_b_r[0];
  assign out_ch.bitan_y     = out_b_r[1];
  assign out_ch.bitan_z     = out_b_r[2];
  assign out_ch.degenerate  = out_degen_r;
endmodule
`default_nettype wire

// ===== verif/tangent_basis_accumulator_tb.sv =====
// Self-checking testbench for the tangent basis accumulator: triangles, reads and threshold.
`default_nettype none
module tangent_basis_accumulator_tb;
  import tba_pkg::*;

  typedef struct {
    logic kind;
    logic signed [15:0] t[3];
    logic signed [15:0] b[3];
    logic degen;
  } basis_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  tba_in_if in_ch ();
  tba_out_if out_ch ();

  tangent_basis_accumulator #(.VERTEX_COUNT(1024)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [15:0] thresh_m;
  int corners_held;
  longint c0_m[5];
  longint c1_m[5];
  int id0_m;
  int id1_m;
  longint tan_sum[1024][3];
  longint bit_sum[1024][3];

  basis_t expected_q[$];
  int errors = 0;
  bit rand_ready = 1'b1;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_CORNER;
    in_ch.vertex_index = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.tex_u = '0;
    in_ch.tex_v = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint sat_delta(longint a, longint b);
    longint d;
    d = b - a;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483647) d = -64'sd2147483647;
    return d;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  task automatic unit_vector(input longint v[3], output logic signed [15:0] o[3]);
    longint unsigned a[3], m, sq, n, q;
    m = 0;
    sq = 0;
    for (int k = 0; k < 3; k++) begin
      a[k] = (v[k] < 0) ? -v[k] : v[k];
      if (a[k] > m) m = a[k];
    end
    if (m == 0) begin
      for (int k = 0; k < 3; k++) o[k] = '0;
      return;
    end
    while (m >= (64'd1 << 30)) begin
      m >>= 1;
      for (int k = 0; k < 3; k++) a[k] >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      m <<= 1;
      for (int k = 0; k < 3; k++) a[k] <<= 1;
    end
    for (int k = 0; k < 3; k++) sq += a[k] * a[k];
    n = root64(sq);
    for (int k = 0; k < 3; k++) begin
      q = (a[k] * 16384 + n / 2) / n;
      o[k] = (v[k] < 0) ? -q[15:0] : q[15:0];
    end
  endtask

  task automatic accumulate(inout longint s[3], input logic signed [15:0] v[3]);
    for (int k = 0; k < 3; k++) begin
      s[k] += v[k];
      if (s[k] > 1048575) s[k] = 1048575;
      if (s[k] < -1048576) s[k] = -1048576;
    end
  endtask

  task automatic predict_basis(input logic op, input int idx, input longint c[5]);
    basis_t r;
    longint p[3], q[3], tv[3], bv[3], s1, t1, s2, t2, det;
    longint unsigned adet;
    int ids[3];
    if (op == OP_READ) begin
      r.kind = KIND_READ;
      r.degen = 1'b0;
      unit_vector(tan_sum[idx], r.t);
      unit_vector(bit_sum[idx], r.b);
      expected_q.insert(expected_q.size(), r);
      return;
    end
    if (corners_held == 0) begin
      c0_m = c;
      id0_m = idx;
      corners_held = 1;
      return;
    end
    if (corners_held == 1) begin
      c1_m = c;
      id1_m = idx;
      corners_held = 2;
      return;
    end
    corners_held = 0;
    for (int k = 0; k < 3; k++) begin
      p[k] = sat_delta(c0_m[k], c1_m[k]);
      q[k] = sat_delta(c0_m[k], c[k]);
    end
    s1 = sat_delta(c0_m[3], c1_m[3]);
    t1 = sat_delta(c0_m[4], c1_m[4]);
    s2 = sat_delta(c0_m[3], c[3]);
    t2 = sat_delta(c0_m[4], c[4]);
    for (int k = 0; k < 3; k++) begin
      tv[k] = t2 * p[k] - t1 * q[k];
      bv[k] = s1 * q[k] - s2 * p[k];
    end
    det = s1 * t2 - s2 * t1;
    adet = (det < 0) ? -det : det;
    r.kind = KIND_TRI;
    r.degen = adet <= (longint'(thresh_m) << 16);
    unit_vector(tv, r.t);
    unit_vector(bv, r.b);
    if (!r.degen && det < 0) begin
      for (int k = 0; k < 3; k++) begin
        r.t[k] = -r.t[k];
        r.b[k] = -r.b[k];
      end
    end
    ids[0] = id0_m;
    ids[1] = id1_m;
    ids[2] = idx;
    for (int k = 0; k < 3; k++) begin
      accumulate(tan_sum[ids[k]], r.t);
      accumulate(bit_sum[ids[k]], r.b);
    end
    expected_q.insert(expected_q.size(), r);
  endtask

  task automatic send_word(input logic op, input int idx, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz,
                           input logic [31:0] u, input logic [31:0] v);
    longint c[5];
    int gap;
    gap = rand_ready ? $urandom_range(0, 19) : 0;
    // drop valid only when idling before this word
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.vertex_index <= idx[9:0];
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.pos_z <= pz;
    in_ch.tex_u <= u;
    in_ch.tex_v <= v;
    do @(posedge clk); while (!in_ch.ready);
    c[0] = longint'($signed(px));
    c[1] = longint'($signed(py));
    c[2] = longint'($signed(pz));
    c[3] = longint'($signed(u));
    c[4] = longint'($signed(v));
    predict_basis(op, idx, c);
  endtask

  task automatic send_corner(input int idx);
    int sh;
    // mostly modest coordinates, sometimes full range
    if ($urandom_range(0, 7) == 0)
      send_word(OP_CORNER, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
    else begin
      sh = $urandom_range(4, 20);
      send_word(OP_CORNER, idx, $signed($urandom) >>> sh, $signed($urandom) >>> sh,
                $signed($urandom) >>> sh, $signed($urandom) >>> sh,
                $signed($urandom) >>> sh);
    end
  endtask

  task automatic send_read(input int idx);
    send_word(OP_READ, idx, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // triangle work may still be in flight after the last result
    repeat (300) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [15:0] th);
    cfg_we <= 1'b1;
    cfg_wdata <= th;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh_m = th;
  endtask

  // result checker with random stall
  always @(posedge clk) begin
    basis_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result kind %0d", $time, out_ch.result_kind);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.kind !== out_ch.result_kind || e.t[0] !== out_ch.tan_x ||
            e.t[1] !== out_ch.tan_y || e.t[2] !== out_ch.tan_z ||
            e.b[0] !== out_ch.bitan_x || e.b[1] !== out_ch.bitan_y ||
            e.b[2] !== out_ch.bitan_z || e.degen !== out_ch.degenerate) begin
          $display("%0t: mismatch expected k%0d t(%0d %0d %0d) b(%0d %0d %0d) d%0d",
                   $time, e.kind, e.t[0], e.t[1], e.t[2], e.b[0], e.b[1], e.b[2], e.degen);
          $display("%0t:          actual k%0d t(%0d %0d %0d) b(%0d %0d %0d) d%0d",
                   $time, out_ch.result_kind, out_ch.tan_x, out_ch.tan_y, out_ch.tan_z,
                   out_ch.bitan_x, out_ch.bitan_y, out_ch.bitan_z, out_ch.degenerate);
          errors++;
        end
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready && rand_ready) stall = $urandom_range(0, 19);
      end
    end
  end

  task automatic test_directed();
    // degenerate: all equal texture coordinates, then zero vertex read
    send_word(OP_CORNER, 0, 0, 0, 0, 0, 0);
    send_word(OP_CORNER, 1, 32'h0001_0000, 0, 0, 0, 0);
    send_word(OP_CORNER, 2, 0, 32'h0001_0000, 0, 0, 0);
    send_read(5);
    // right triangle with positive then negative determinant
    send_word(OP_CORNER, 3, 0, 0, 0, 0, 0);
    send_word(OP_CORNER, 4, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
    send_word(OP_CORNER, 5, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
    send_word(OP_CORNER, 6, 0, 0, 0, 0, 0);
    send_word(OP_CORNER, 7, 32'h0001_0000, 0, 0, 0, 32'h0001_0000);
    send_word(OP_CORNER, 1023, 0, 0, 32'h0001_0000, 32'h0001_0000, 0);
    // delta saturation at field extremes, read in the middle of a triangle
    send_word(OP_CORNER, 1023, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h8000_0000, 32'h7fff_ffff);
    send_read(1023);
    send_word(OP_CORNER, 1023, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h8000_0000);
    send_word(OP_CORNER, 1022, 32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff);
    send_read(1023);
    send_read(0);
    send_read(3);
    // send two triangles whose corners all name one vertex
    for (int i = 0; i < 2; i++) begin
      send_word(OP_CORNER, 9, 0, 0, 0, 0, 0);
      send_word(OP_CORNER, 9, 32'h0001_0000, 0, 0, 32'h0001_0000, 0);
      send_word(OP_CORNER, 9, 0, 32'h0001_0000, 0, 0, 32'h0001_0000);
    end
    send_read(9);
    drain();
  endtask

  task automatic test_threshold(input logic [15:0] th, input int count);
    int base;
    write_threshold(th);
    base = $urandom_range(0, 1023);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) send_read($urandom_range(0, 1023));
      else if ($urandom_range(0, 3) == 0) send_corner($urandom_range(0, 1023));
      else send_corner((base + $urandom_range(0, 15)) % 1024);
    end
    // close any open triangle
    while (corners_held != 0) send_corner($urandom_range(0, 1023));
    send_read(base);
    drain();
  endtask

  task automatic test_burst();
    rand_ready = 1'b0;
    for (int i = 0; i < 60; i++) send_corner($urandom_range(0, 31));
    send_read($urandom_range(0, 31));
    drain();
    rand_ready = 1'b1;
  endtask

  initial begin
    thresh_m = 16'd7;
    corners_held = 0;
    for (int i = 0; i < 1024; i++)
      for (int k = 0; k < 3; k++) begin
        tan_sum[i][k] = 0;
        bit_sum[i][k] = 0;
      end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_threshold(16'd0, 220);
    test_threshold(16'hffff, 200);
    test_threshold(16'd7, 220);
    test_burst();
    test_threshold(16'd300, 230);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
